@@ hw/rtl/stk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_pkg: shared types and constants of the stack machine executor
// Opcodes, status codes, stack cell controls, controller states and sizes.
// ----------------------------------------------------------------------------
package stk_pkg;

    // stack size and derived widths
    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // instruction opcodes
    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_ADD     = 3'd2,
        OP_SUB     = 3'd3,
        OP_DIV     = 3'd4,
        OP_OUT     = 3'd5,
        OP_HALT    = 3'd6,
        OP_INVALID = 3'd7
    } t_opcode;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_HALTED  = 3'd4
    } t_status;

    // per-cell move: keep, take from the cell above, take from the cell below
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_DOWN = 2'd1,
        CELL_UP   = 2'd2
    } t_cell_op;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DIV  = 2'd2
    } t_state;

endpackage

`default_nettype wire

@@ hw/rtl/stk_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_cell: one entry of the shifting operand stack
// Holds a word, or takes it from the neighbour nearer the top or further down.
// ----------------------------------------------------------------------------
module stk_cell (
    input  wire logic                      i_clk,
    input  wire stk_pkg::t_cell_op         i_op,
    input  wire logic [stk_pkg::DATA_W-1:0] i_prev,
    input  wire logic [stk_pkg::DATA_W-1:0] i_next,
    output logic      [stk_pkg::DATA_W-1:0] o_data
);
    import stk_pkg::*;

    logic [DATA_W-1:0] r_data;

    // entry register, no reset as contents are undefined until pushed
    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_DOWN: r_data <= i_prev;
            CELL_UP:   r_data <= i_next;
            default:   r_data <= r_data;
        endcase
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

@@ hw/rtl/stk_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module stk_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [stk_pkg::DATA_W-1:0] i_dividend,
    input  wire logic [stk_pkg::DATA_W-1:0] i_divisor,
    output logic                            o_busy,
    output logic      [stk_pkg::DATA_W-1:0] o_quotient
);
    import stk_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_dvs;
    logic [DATA_W:0]      w_shift;
    logic                 w_fits;

    // partial remainder step
    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_fits  = (w_shift >= {1'b0, r_dvs});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath: load magnitudes, then shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            r_quo <= i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
            r_dvs <= i_divisor[DATA_W-1] ? (DATA_W'(0) - i_divisor) : i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= DATA_W'(w_shift - {1'b0, r_dvs});
            end else begin
                r_rem <= w_shift[DATA_W-1:0];
            end
            r_quo <= {r_quo[DATA_W-2:0], w_fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

endmodule

`default_nettype wire

@@ hw/rtl/stack_machine_executor_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_executor_top: stack calculator with a shifting cell stack
// Runs one instruction per request on a row of stack cells, top in cell 0.
// ----------------------------------------------------------------------------
// flow: a request is taken in idle, decoded in exec and committed into the
//          output stage; div first runs the one-bit-per-cycle 32-step divider
//          in the div state; commit waits for a free output stage, and a new request
//          is taken while the previous result still waits in the output stage
// reset: synchronous, clears the stack count, the halt flag and the control;
//          stack cells keep their contents but count as empty
module stack_machine_executor_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [31:0] i_operand,
    // result channel
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic             o_out_valid,
    output logic      [31:0] o_out_value,
    output logic      [2:0]  o_status,
    output logic             o_halted,
    output logic      [6:0]  o_stack_depth
);
    import stk_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_opcode           r_cmd;
    logic [DATA_W-1:0] r_operand;
    logic [CNT_W-1:0]  r_count;
    logic              r_halt;

    logic              r_res_valid;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    t_status           r_status;
    logic [6:0]        r_stack_depth;

    t_status           w_status;
    logic              w_halt;
    logic [CNT_W-1:0]  w_count;
    t_cell_op          w_op_top;
    t_cell_op          w_op_rest;
    t_cell_op          w_cell_top;
    t_cell_op          w_cell_rest;
    logic [DATA_W-1:0] w_load;
    logic              w_emit;
    logic [DATA_W-1:0] w_emit_val;
    logic              w_need_div;
    logic              w_out_free;
    logic              w_accept;
    logic              w_commit;
    logic              w_div_start;
    logic              w_div_busy;
    logic [DATA_W-1:0] w_div_q;
    logic [DATA_W-1:0] w_data [STACK_DEPTH];

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_res_valid || !i_res_stall;

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= t_opcode'(i_cmd);
            r_operand <= i_operand;
        end
    end

    // controller state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // controller next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_need_div) begin
                    n_state = S_DIV;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (!w_div_busy && w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_div_start = 1'b0;
        w_commit    = 1'b0;
        case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_EXEC: begin
                w_div_start = w_need_div;
                w_commit    = !w_need_div && w_out_free;
            end
            S_DIV:   w_commit = !w_div_busy && w_out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    // instruction decode: status, new count and stack moves
    always_comb begin
        w_status   = ST_OK;
        w_halt     = r_halt;
        w_count    = r_count;
        w_op_top   = CELL_HOLD;
        w_op_rest  = CELL_HOLD;
        w_load     = r_operand;
        w_emit     = 1'b0;
        w_emit_val = '0;
        w_need_div = 1'b0;
        if (r_halt) begin
            w_status = ST_HALTED;
        end else begin
            case (r_cmd)
                OP_PUSH: begin
                    if (r_count == CNT_W'(STACK_DEPTH)) begin
                        w_status = ST_OVER;
                    end else begin
                        w_op_top  = CELL_DOWN;
                        w_op_rest = CELL_DOWN;
                        w_count   = r_count + CNT_W'(1);
                    end
                end
                OP_POP, OP_OUT: begin
                    if (r_count == '0) begin
                        w_status = ST_UNDER;
                    end else begin
                        w_op_top  = CELL_UP;
                        w_op_rest = CELL_UP;
                        w_count   = r_count - CNT_W'(1);
                        if (r_cmd == OP_OUT) begin
                            w_emit     = 1'b1;
                            w_emit_val = w_data[0];
                        end
                    end
                end
                OP_ADD, OP_SUB, OP_DIV: begin
                    if (r_count < CNT_W'(2)) begin
                        w_status = ST_UNDER;
                    end else if (r_cmd == OP_DIV && w_data[0] == '0) begin
                        w_status = ST_DIVZERO;
                    end else begin
                        // result replaces the second entry, the rest close up
                        w_op_top  = CELL_DOWN;
                        w_op_rest = CELL_UP;
                        w_count   = r_count - CNT_W'(1);
                        case (r_cmd)
                            OP_ADD:  w_load = w_data[1] + w_data[0];
                            OP_SUB:  w_load = w_data[1] - w_data[0];
                            default: w_load = w_div_q;
                        endcase
                        w_need_div = (r_cmd == OP_DIV) && (r_state == S_EXEC);
                    end
                end
                default: w_halt = 1'b1;
            endcase
        end
    end

    // stack moves only take effect on commit
    assign w_cell_top  = w_commit ? w_op_top  : CELL_HOLD;
    assign w_cell_rest = w_commit ? w_op_rest : CELL_HOLD;

    // row of stack cells
    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        if (gi == 0) begin : g_top
            stk_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (w_cell_top),
                .i_prev (w_load),
                .i_next (w_data[gi+1]),
                .o_data (w_data[gi])
            );
        end else if (gi == STACK_DEPTH - 1) begin : g_bottom
            stk_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (w_cell_rest),
                .i_prev (w_data[gi-1]),
                .i_next (w_data[gi]),
                .o_data (w_data[gi])
            );
        end else begin : g_mid
            stk_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (w_cell_rest),
                .i_prev (w_data[gi-1]),
                .i_next (w_data[gi+1]),
                .o_data (w_data[gi])
            );
        end
    end

    // divider, a is the second entry and b the top
    stk_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_data[1]),
        .i_divisor  (w_data[0]),
        .o_busy     (w_div_busy),
        .o_quotient (w_div_q)
    );

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_halt  <= 1'b0;
        end else if (w_commit) begin
            r_count <= w_count;
            r_halt  <= w_halt;
        end
    end

    // output stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_commit) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    // output stage payload
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_valid   <= w_emit;
            r_out_value   <= w_emit_val;
            r_status      <= w_status;
            r_stack_depth <= 7'(w_count);
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_out_valid   = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_status      = r_status;
    assign o_halted      = r_halt;
    assign o_stack_depth = r_stack_depth;

    // a committed result always lands in the output stage
    a_commit_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_res_valid)
        else $error("committed result not presented");

    // the stack count never passes the stack size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond stack size");

    // halt holds until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag dropped without reset");

    // a divide start is followed by a busy divider in the divide state
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (r_state == S_DIV) && w_div_busy)
        else $error("divide did not start");

    // no commit while the divider still works
    a_no_early_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> !w_commit)
        else $error("commit while divider busy");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stack machine executor
// Drives opcode and operand requests over a valid/stall channel, mirrors the
// operand stack in a scoreboard and checks every result field by field. Runs
// directed corner cases, then random grow/shrink sequences under several
// idling mixes, and finally halts the machine and checks that later requests
// are ignored.
// ----------------------------------------------------------------------------
module tb;
    import stk_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 375;
    localparam int TAIL_CYCLES = 40;

    // one expected or observed result
    typedef struct packed {
        logic              out_valid;
        logic [DATA_W-1:0] out_value;
        logic [2:0]        status;
        logic              halted;
        logic [6:0]        depth;
    } t_calc_result;

    // ------------------------------------------------------------------
    // scoreboard: mirrored operand stack and queue of pending results
    // ------------------------------------------------------------------
    class t_stack_calc_scoreboard;
        logic [DATA_W-1:0] cells [STACK_DEPTH];
        int unsigned       depth;
        bit                halt_seen;
        t_calc_result      pending_q [$];
        int unsigned       errors;

        function new();
            depth     = 0;
            halt_seen = 1'b0;
            errors    = 0;
        endfunction

        // signed quotient truncated toward zero, worked on magnitudes
        function logic [DATA_W-1:0] trunc_quotient(logic [DATA_W-1:0] a,
                                                   logic [DATA_W-1:0] b);
            logic [DATA_W-1:0] mag_a;
            logic [DATA_W-1:0] mag_b;
            logic [DATA_W-1:0] q;
            mag_a = a[DATA_W-1] ? (~a + 1'b1) : a;
            mag_b = b[DATA_W-1] ? (~b + 1'b1) : b;
            q     = mag_a / mag_b;
            return (a[DATA_W-1] != b[DATA_W-1]) ? (~q + 1'b1) : q;
        endfunction

        // work out the result of an accepted request
        function void note_request(logic [2:0] cmd, logic [DATA_W-1:0] operand);
            t_calc_result      r;
            logic [DATA_W-1:0] a;
            logic [DATA_W-1:0] b;
            r        = '0;
            r.status = ST_OK;
            if (halt_seen) begin
                r.status = ST_HALTED;
            end else begin
                case (t_opcode'(cmd))
                    OP_PUSH: begin
                        if (depth >= STACK_DEPTH) begin
                            r.status = ST_OVER;
                        end else begin
                            cells[depth] = operand;
                            depth++;
                        end
                    end
                    OP_POP, OP_OUT: begin
                        if (depth == 0) begin
                            r.status = ST_UNDER;
                        end else begin
                            depth--;
                            if (cmd == OP_OUT) begin
                                r.out_valid = 1'b1;
                                r.out_value = cells[depth];
                            end
                        end
                    end
                    OP_ADD, OP_SUB, OP_DIV: begin
                        if (depth < 2) begin
                            r.status = ST_UNDER;
                        end else begin
                            b = cells[depth-1];
                            a = cells[depth-2];
                            if (cmd == OP_DIV && b == '0) begin
                                r.status = ST_DIVZERO;
                            end else begin
                                if (cmd == OP_ADD)
                                    cells[depth-2] = a + b;
                                else if (cmd == OP_SUB)
                                    cells[depth-2] = a - b;
                                else
                                    cells[depth-2] = trunc_quotient(a, b);
                                depth--;
                            end
                        end
                    end
                    default: begin
                        halt_seen = 1'b1;
                    end
                endcase
            end
            r.halted = halt_seen;
            r.depth  = depth[6:0];
            pending_q.push_back(r);
        endfunction

        // compare an accepted result with the oldest expectation
        function void check_result(t_calc_result act);
            t_calc_result exp_r;
            if (pending_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (act.out_valid !== exp_r.out_valid) begin
                $error("out_valid: expected %0b, got %0b", exp_r.out_valid, act.out_valid);
                errors++;
            end
            if (act.out_value !== exp_r.out_value) begin
                $error("out_value: expected %h, got %h", exp_r.out_value, act.out_value);
                errors++;
            end
            if (act.status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, act.status);
                errors++;
            end
            if (act.halted !== exp_r.halted) begin
                $error("halted: expected %0b, got %0b", exp_r.halted, act.halted);
                errors++;
            end
            if (act.depth !== exp_r.depth) begin
                $error("stack_depth: expected %0d, got %0d", exp_r.depth, act.depth);
                errors++;
            end
        endfunction
    endclass

    // clock, reset and block inputs, known from time zero
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [2:0]        i_cmd       = '0;
    logic [DATA_W-1:0] i_operand   = '0;
    logic              i_res_stall = 1'b0;

    logic              o_in_stall;
    logic              o_res_valid;
    logic              o_out_valid;
    logic [DATA_W-1:0] o_out_value;
    logic [2:0]        o_status;
    logic              o_halted;
    logic [6:0]        o_stack_depth;

    t_stack_calc_scoreboard sb;
    int                     tx_pct      = 0;
    int                     rx_pct      = 0;
    int                     cycle_count = 0;
    int                     gen_depth   = 0;

    stack_machine_executor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_operand     (i_operand),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_out_valid   (o_out_valid),
        .o_out_value   (o_out_value),
        .o_status      (o_status),
        .o_halted      (o_halted),
        .o_stack_depth (o_stack_depth)
    );

    // clock
    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_res_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
    end

    // note accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_request(i_cmd, i_operand);
    end

    // check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall)
            sb.check_result({o_out_valid, o_out_value, o_status, o_halted, o_stack_depth});
    end

    // send one request, with random idle cycles first
    task automatic send_request(input logic [2:0] cmd, input logic [DATA_W-1:0] operand);
        while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_operand  <= operand;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // rough depth tracking, used only to steer the random mix
        case (t_opcode'(cmd))
            OP_PUSH:                if (gen_depth < STACK_DEPTH) gen_depth++;
            OP_POP, OP_OUT:         if (gen_depth > 0) gen_depth--;
            OP_ADD, OP_SUB, OP_DIV: if (gen_depth >= 2) gen_depth--;
            default: ;
        endcase
    endtask

    // hold the sender until every expected result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        // let the last accepted request reach the scoreboard first
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        gen_depth = sb.depth;
    endtask

    // operand mix: full range, small values, extremes and scaled values
    function automatic logic [DATA_W-1:0] rand_operand();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return $urandom;
        else if (sel < 60)
            return DATA_W'($signed($urandom_range(32)) - 16);
        else if (sel < 75) begin
            case ($urandom_range(4))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                3:       return 32'hffff_ffff;
                default: return 32'h0000_0001;
            endcase
        end else
            return $signed($urandom) >>> $urandom_range(31);
    endfunction

    // opcode mix for a mode: 0 grow, 1 shrink, 2 mixed
    function automatic logic [2:0] pick_cmd(int mode);
        int unsigned push_pct;
        int unsigned sel;
        push_pct = (mode == 0) ? 75 : (mode == 1) ? 15 : 45;
        if ($urandom_range(99) < push_pct)
            return OP_PUSH;
        sel = $urandom_range(99);
        if (sel < 15)
            return OP_POP;
        else if (sel < 45)
            return OP_OUT;
        else if (sel < 65)
            return OP_ADD;
        else if (sel < 85)
            return OP_SUB;
        else
            return OP_DIV;
    endfunction

    // stimulus
    initial begin
        int mode;
        int mode_left;
        int phase_tx [4];
        int phase_rx [4];
        phase_tx = '{0, 50, 0, 25};
        phase_rx = '{0, 0, 50, 25};
        sb = new();

        // reset
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: underflow on an empty stack for every consuming opcode
        send_request(OP_POP, $urandom);
        send_request(OP_OUT, $urandom);
        send_request(OP_ADD, $urandom);
        send_request(OP_SUB, $urandom);
        send_request(OP_DIV, $urandom);
        // underflow with a single entry, then wrapping add
        send_request(OP_PUSH, 32'h7fff_ffff);
        send_request(OP_ADD, $urandom);
        send_request(OP_PUSH, 32'h0000_0001);
        send_request(OP_ADD, $urandom);
        // divide by zero leaves the stack alone
        send_request(OP_PUSH, 32'h0000_0000);
        send_request(OP_DIV, $urandom);
        send_request(OP_POP, $urandom);
        // most negative over minus one wraps
        send_request(OP_PUSH, 32'hffff_ffff);
        send_request(OP_DIV, $urandom);
        // wrapping subtract
        send_request(OP_PUSH, 32'h0000_0001);
        send_request(OP_SUB, $urandom);
        // truncation toward zero
        send_request(OP_PUSH, -32'sd7);
        send_request(OP_PUSH, 32'sd2);
        send_request(OP_DIV, $urandom);
        send_request(OP_PUSH, 32'sd7);
        send_request(OP_PUSH, -32'sd2);
        send_request(OP_DIV, $urandom);
        send_request(OP_OUT, $urandom);
        send_request(OP_OUT, $urandom);
        send_request(OP_OUT, $urandom);
        wait_drained();

        // random phases with different idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            tx_pct = phase_tx[ph];
            rx_pct <= phase_rx[ph];
            mode      = 0;
            mode_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(2);
                    mode_left = $urandom_range(80, 10);
                end
                mode_left--;
                // after topping out, force a few overflow pushes then drain
                if (mode == 0 && gen_depth >= STACK_DEPTH && $urandom_range(3) == 0)
                    mode = 1;
                send_request(pick_cmd(mode), rand_operand());
            end
            wait_drained();
        end

        // halt by halt or invalid opcode, then everything is ignored
        send_request($urandom_range(1) ? OP_HALT : OP_INVALID, $urandom);
        for (int n = 0; n < 12; n++)
            send_request(3'($urandom_range(7)), $urandom);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
